// ===== sv/skt_pkg.sv =====
// Shared types and constants for the sorted key table.
// Used by the channel interfaces and the top level; no dependencies.
package skt_pkg;

  localparam int unsigned TABLE_DEPTH = 64;
  localparam int unsigned KEY_BITS    = 40;
  localparam int unsigned SCORE_BITS  = 14;
  localparam int unsigned IDX_W       = $clog2(TABLE_DEPTH);
  localparam int unsigned CNT_W       = $clog2(TABLE_DEPTH + 1);

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_DELETE = 1'b1
  } op_e;

  typedef enum logic [2:0] {
    ST_INSERTED  = 3'd0,
    ST_DELETED   = 3'd1,
    ST_NOT_FOUND = 3'd2,
    ST_EMPTY     = 3'd3,
    ST_FULL      = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE  = 2'd0,
    S_RUN   = 2'd1,
    S_PLACE = 2'd2,
    S_DONE  = 2'd3
  } state_e;

  typedef struct packed {
    logic [KEY_BITS-1:0]   key;
    logic [SCORE_BITS-1:0] score;
  } entry_t;

endpackage

// ===== sv/skt_in_if.sv =====
// Request channel of the sorted key table: valid/ready plus one request word.
// Depends on skt_pkg for field widths.
interface skt_in_if
  import skt_pkg::*;
();
  logic                  valid;
  logic                  ready;
  logic                  opcode;
  logic [KEY_BITS-1:0]   record_key;
  logic [SCORE_BITS-1:0] score_value;

  modport source (output valid, output opcode, output record_key, output score_value,
                  input ready);
  modport sink   (input valid, input opcode, input record_key, input score_value,
                  output ready);
endinterface

// ===== sv/skt_out_if.sv =====
// Response channel of the sorted key table: valid/ready plus one response word.
// Depends on skt_pkg for field widths.
interface skt_out_if
  import skt_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [2:0]       status;
  logic [CNT_W-1:0] entry_count;
  logic [IDX_W-1:0] position;

  modport source (output valid, output status, output entry_count, output position,
                  input ready);
  modport sink   (input valid, input status, input entry_count, input position,
                  output ready);
endinterface

// ===== sv/sorted_key_table_insert_delete.sv =====
// Sorted key table: record memory, scan/shift sequencer and response register.
// Depends on skt_pkg, skt_in_if and skt_out_if.
//
// Usage:
//   in_i carries request words (opcode, record_key, score_value); out_o returns
//   one response word (status, entry_count, position) per request. Records sit
//   in ascending key order in a single-port-write, single-port-read memory.
//   An insert scans down from the last record, moving each record whose key is
//   not below the new one up a place, then writes the new record. A delete
//   scans up from position 0 until the key is reached, then moves the records
//   behind it down a place. One memory read and one write happen per cycle,
//   so the scan over the memory port sets the rate.
//   An insert passes through the scan in S_RUN (skipped when the table is empty),
//   then S_PLACE and S_DONE; a delete ends its scan in S_DONE. An insert into
//   a full table or a delete from an empty one goes straight to S_DONE.
//   in_i.ready is high only while no request is in work, so the next request
//   can be accepted in the same cycle as the response turns valid.
//   A finished response waits in the output register while out_o.ready is
//   low, and a new request is accepted meanwhile; it holds at its end until
//   the register frees.
//   Reset empties the table at once (record count cleared); memory contents
//   are left as they are and are never read before being written.
module sorted_key_table_insert_delete
  import skt_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  skt_in_if.sink    in_i,
  skt_out_if.source out_o
);

  entry_t mem_q [TABLE_DEPTH];
  entry_t rd_q;

  state_e                state_q, state_d;
  op_e                   op_q, op_d;
  logic [KEY_BITS-1:0]   key_q, key_d;
  logic [SCORE_BITS-1:0] score_q, score_d;
  logic [CNT_W-1:0]      count_q, count_d;
  logic [IDX_W-1:0]      idx_q, idx_d;
  logic [IDX_W-1:0]      pos_q, pos_d;
  logic                  found_q, found_d;
  status_e               stat_q, stat_d;

  logic                  ovld_q, ovld_d;
  logic                  oload;
  status_e               ost_q;
  logic [CNT_W-1:0]      ocnt_q;
  logic [IDX_W-1:0]      opos_q;

  logic                  mem_we, mem_re;
  logic [IDX_W-1:0]      mem_waddr, mem_raddr;
  entry_t                mem_wdata;
  logic [IDX_W-1:0]      last_idx;
  logic                  at_last;

  assign last_idx = IDX_W'(count_q - CNT_W'(1));
  assign at_last  = (idx_q == last_idx);

  // Record memory: one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_q <= mem_q[mem_raddr];
    end
  end

  always_comb begin
    state_d   = state_q;
    op_d      = op_q;
    key_d     = key_q;
    score_d   = score_q;
    count_d   = count_q;
    idx_d     = idx_q;
    pos_d     = pos_q;
    found_d   = found_q;
    stat_d    = stat_q;
    ovld_d    = ovld_q;
    oload     = 1'b0;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_waddr = idx_q;
    mem_raddr = idx_q;
    mem_wdata = rd_q;

    if (ovld_q && out_o.ready) begin
      ovld_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_i.valid) begin
          op_d    = op_e'(in_i.opcode);
          key_d   = in_i.record_key;
          score_d = in_i.score_value;
          found_d = 1'b0;
          pos_d   = '0;
          if (op_e'(in_i.opcode) == OP_INSERT) begin
            if (count_q == CNT_W'(TABLE_DEPTH)) begin
              stat_d  = ST_FULL;
              state_d = S_DONE;
            end else if (count_q == '0) begin
              state_d = S_PLACE;
            end else begin
              mem_re    = 1'b1;
              mem_raddr = last_idx;
              idx_d     = last_idx;
              state_d   = S_RUN;
            end
          end else begin
            if (count_q == '0) begin
              stat_d  = ST_EMPTY;
              state_d = S_DONE;
            end else begin
              mem_re    = 1'b1;
              mem_raddr = '0;
              idx_d     = '0;
              state_d   = S_RUN;
            end
          end
        end
      end

      S_RUN: begin
        if (op_q == OP_INSERT) begin
          // rd_q holds the record at idx_q; move it up while not below the new key
          if (rd_q.key >= key_q) begin
            mem_we    = 1'b1;
            mem_waddr = idx_q + IDX_W'(1);
            if (idx_q == '0) begin
              pos_d   = '0;
              state_d = S_PLACE;
            end else begin
              mem_re    = 1'b1;
              mem_raddr = idx_q - IDX_W'(1);
              idx_d     = idx_q - IDX_W'(1);
            end
          end else begin
            pos_d   = idx_q + IDX_W'(1);
            state_d = S_PLACE;
          end
        end else if (found_q) begin
          // close the gap: move each trailing record down a place
          mem_we    = 1'b1;
          mem_waddr = idx_q - IDX_W'(1);
          if (at_last) begin
            count_d = count_q - CNT_W'(1);
            stat_d  = ST_DELETED;
            state_d = S_DONE;
          end else begin
            mem_re    = 1'b1;
            mem_raddr = idx_q + IDX_W'(1);
            idx_d     = idx_q + IDX_W'(1);
          end
        end else if (rd_q.key == key_q) begin
          pos_d = idx_q;
          if (at_last) begin
            count_d = count_q - CNT_W'(1);
            stat_d  = ST_DELETED;
            state_d = S_DONE;
          end else begin
            found_d   = 1'b1;
            mem_re    = 1'b1;
            mem_raddr = idx_q + IDX_W'(1);
            idx_d     = idx_q + IDX_W'(1);
          end
        end else if (rd_q.key < key_q && !at_last) begin
          mem_re    = 1'b1;
          mem_raddr = idx_q + IDX_W'(1);
          idx_d     = idx_q + IDX_W'(1);
        end else begin
          stat_d  = ST_NOT_FOUND;
          state_d = S_DONE;
        end
      end

      S_PLACE: begin
        mem_we          = 1'b1;
        mem_waddr       = pos_q;
        mem_wdata.key   = key_q;
        mem_wdata.score = score_q;
        count_d         = count_q + CNT_W'(1);
        stat_d          = ST_INSERTED;
        state_d         = S_DONE;
      end

      S_DONE: begin
        // hold until the response register is free
        if (!ovld_q || out_o.ready) begin
          oload   = 1'b1;
          ovld_d  = 1'b1;
          state_d = S_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      found_q <= 1'b0;
      ovld_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      found_q <= found_d;
      ovld_q  <= ovld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q    <= op_d;
    key_q   <= key_d;
    score_q <= score_d;
    idx_q   <= idx_d;
    pos_q   <= pos_d;
    stat_q  <= stat_d;
    if (oload) begin
      ost_q  <= stat_q;
      ocnt_q <= count_q;
      opos_q <= pos_q;
    end
  end

  assign in_i.ready        = (state_q == S_IDLE);
  assign out_o.valid       = ovld_q;
  assign out_o.status      = ost_q;
  assign out_o.entry_count = ocnt_q;
  assign out_o.position    = opos_q;

  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(TABLE_DEPTH))
    else $error("record count beyond table depth");

  a_insert_pos : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ovld_q && ost_q == ST_INSERTED) |-> ({1'b0, opos_q} < ocnt_q))
    else $error("insert position outside table");

  a_fail_pos_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ovld_q && (ost_q == ST_NOT_FOUND || ost_q == ST_EMPTY || ost_q == ST_FULL))
      |-> (opos_q == '0))
    else $error("nonzero position on failed request");

  a_full_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ovld_q && ost_q == ST_FULL) |-> (ocnt_q == CNT_W'(TABLE_DEPTH)))
    else $error("full status with table not full");

  a_done_load : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE && !ovld_q) |=> (ovld_q && state_q == S_IDLE))
    else $error("finished request not loaded into response register");

endmodule

// ===== bench/tb.sv =====
// Self-checking bench for sorted_key_table_insert_delete: random request words
// checked against a shadow copy of the sorted table. Needs skt_pkg and the
// skt_in_if / skt_out_if interfaces compiled ahead of it.
module tb;
  import skt_pkg::*;

  localparam int ITEM_TARGET      = 1420;
  localparam int LONG_HOLD_AT     = 300;
  localparam int LONG_HOLD_CYCLES = 1000;
  localparam int DRAIN_CYCLES     = 100;
  localparam int LIMIT_CYCLES     = 1500000;

  typedef struct {
    op_e                   op;
    logic [KEY_BITS-1:0]   key;
    logic [SCORE_BITS-1:0] score;
    bit                    wait_idle;  // hold until every response is back
  } request_t;

  typedef struct {
    status_e          status;
    logic [CNT_W-1:0] count;
    logic [IDX_W-1:0] pos;
  } response_t;

  logic clk;
  logic rst_n;

  skt_in_if  req_if ();
  skt_out_if rsp_if ();

  sorted_key_table_insert_delete dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (req_if),
    .out_o  (rsp_if)
  );

  request_t            pending_requests[$];
  response_t           awaited_responses[$];
  logic [KEY_BITS-1:0] live_keys[$];

  // shadow of the table contents
  logic [KEY_BITS-1:0]   shadow_key[TABLE_DEPTH];
  logic [SCORE_BITS-1:0] shadow_score[TABLE_DEPTH];
  int                    shadow_count = 0;

  bit        took_word = 1'b0;
  int        words_accepted = 0;
  int        mismatches = 0;
  int        burst_left = 0;
  int        gap_left = 0;
  int        rx_mode = 0;
  int        rx_mode_left = 0;
  int        hold_left = 0;
  bit        long_hold_done = 1'b0;
  request_t  next_word;
  response_t got_want;
  response_t new_want;

  task automatic apply_to_shadow_table(input op_e op, input logic [KEY_BITS-1:0] key,
                                       input logic [SCORE_BITS-1:0] score,
                                       output response_t res);
    int slot;
    slot = 0;
    res.pos = '0;
    if (op == OP_INSERT) begin
      if (shadow_count >= TABLE_DEPTH) begin
        res.status = ST_FULL;
      end else begin
        while (slot < shadow_count && shadow_key[slot] < key) slot++;
        for (int i = shadow_count; i > slot; i--) begin
          shadow_key[i]   = shadow_key[i-1];
          shadow_score[i] = shadow_score[i-1];
        end
        shadow_key[slot]   = key;
        shadow_score[slot] = score;
        shadow_count++;
        res.status = ST_INSERTED;
        res.pos    = IDX_W'(slot);
      end
    end else if (shadow_count == 0) begin
      res.status = ST_EMPTY;
    end else begin
      while (slot < shadow_count && shadow_key[slot] < key) slot++;
      if (slot >= shadow_count || shadow_key[slot] != key) begin
        res.status = ST_NOT_FOUND;
      end else begin
        for (int i = slot; i < shadow_count - 1; i++) begin
          shadow_key[i]   = shadow_key[i+1];
          shadow_score[i] = shadow_score[i+1];
        end
        shadow_count--;
        res.status = ST_DELETED;
        res.pos    = IDX_W'(slot);
      end
    end
    res.count = CNT_W'(shadow_count);
  endtask

  function automatic void add_insert(input logic [KEY_BITS-1:0] k,
                                     input logic [SCORE_BITS-1:0] s, input bit wait_idle);
    request_t rq;
    rq.op        = OP_INSERT;
    rq.key       = k;
    rq.score     = s;
    rq.wait_idle = wait_idle;
    pending_requests.push_back(rq);
    if (live_keys.size() < TABLE_DEPTH) live_keys.push_back(k);
  endfunction

  function automatic void add_delete(input logic [KEY_BITS-1:0] k, input bit wait_idle);
    request_t rq;
    rq.op        = OP_DELETE;
    rq.key       = k;
    rq.score     = SCORE_BITS'($urandom);
    rq.wait_idle = wait_idle;
    pending_requests.push_back(rq);
    for (int i = 0; i < live_keys.size(); i++) begin
      if (live_keys[i] == k) begin
        live_keys.delete(i);
        break;
      end
    end
  endfunction

  // small keys collide often, so equal-key ordering gets exercised
  function automatic logic [KEY_BITS-1:0] pick_key();
    logic [63:0] wide;
    wide = {$urandom, $urandom};
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return KEY_BITS'($urandom_range(0, 31));
      4:          return {KEY_BITS{1'b1}} - KEY_BITS'($urandom_range(0, 3));
      default:    return wide[KEY_BITS-1:0];
    endcase
  endfunction

  function automatic logic [SCORE_BITS-1:0] pick_score();
    if ($urandom_range(0, 4) == 0) return SCORE_BITS'($urandom_range(0, 16383));
    return SCORE_BITS'($urandom_range(0, 10000));
  endfunction

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    rst_n              = 1'b0;
    req_if.valid       = 1'b0;
    req_if.opcode      = 1'b0;
    req_if.record_key  = '0;
    req_if.score_value = '0;
    rsp_if.ready       = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
  end

  // sender: bursts of words with random gaps between them
  always @(negedge clk) begin
    if (!rst_n) begin
      req_if.valid <= 1'b0;
    end else if (!req_if.valid || took_word) begin
      if (gap_left > 0) begin
        req_if.valid <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (pending_requests.size() != 0 &&
                   !(pending_requests[0].wait_idle && awaited_responses.size() != 0)) begin
        next_word = pending_requests.pop_front();
        req_if.valid       <= 1'b1;
        req_if.opcode      <= next_word.op;
        req_if.record_key  <= next_word.key;
        req_if.score_value <= next_word.score;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 24);
          gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 16);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        req_if.valid <= 1'b0;
      end
    end
  end

  // receiver: own stall pattern, plus one long hold-off to back up the block
  always @(negedge clk) begin
    if (!rst_n) begin
      rsp_if.ready <= 1'b0;
    end else if (!long_hold_done && words_accepted >= LONG_HOLD_AT) begin
      rsp_if.ready   <= 1'b0;
      hold_left      <= LONG_HOLD_CYCLES;
      long_hold_done <= 1'b1;
    end else if (hold_left > 0) begin
      rsp_if.ready <= 1'b0;
      hold_left    <= hold_left - 1;
    end else begin
      if (rx_mode_left == 0) begin
        rx_mode      <= $urandom_range(0, 3);
        rx_mode_left <= $urandom_range(40, 300);
      end else begin
        rx_mode_left <= rx_mode_left - 1;
      end
      case (rx_mode)
        0:       rsp_if.ready <= 1'b1;
        1:       rsp_if.ready <= 1'($urandom_range(0, 1));
        2:       rsp_if.ready <= ($urandom_range(0, 3) == 0);
        default: rsp_if.ready <= ($urandom_range(0, 7) != 0);
      endcase
    end
  end

  // predict on every accepted request word, check every accepted response word
  always @(posedge clk) begin
    took_word <= req_if.valid && req_if.ready;
    if (rst_n && req_if.valid && req_if.ready) begin
      apply_to_shadow_table(op_e'(req_if.opcode), req_if.record_key, req_if.score_value,
                            new_want);
      awaited_responses.push_back(new_want);
      words_accepted++;
    end
    if (rst_n && rsp_if.valid && rsp_if.ready) begin
      if (awaited_responses.size() == 0) begin
        $error("response with none awaited: status %0d count %0d position %0d",
               rsp_if.status, rsp_if.entry_count, rsp_if.position);
        mismatches++;
      end else begin
        got_want = awaited_responses.pop_front();
        if (rsp_if.status !== got_want.status) begin
          $error("status: expected %0d, got %0d", got_want.status, rsp_if.status);
          mismatches++;
        end
        if (rsp_if.entry_count !== got_want.count) begin
          $error("entry_count: expected %0d, got %0d", got_want.count, rsp_if.entry_count);
          mismatches++;
        end
        if (rsp_if.position !== got_want.pos) begin
          $error("position: expected %0d, got %0d", got_want.pos, rsp_if.position);
          mismatches++;
        end
      end
    end
  end

  initial begin
    int ins_pct;
    int len;
    int phase;
    bit first;

    // directed: empty table, key and score extremes, equal keys, misses
    add_delete('0, 1'b0);
    add_insert(KEY_BITS'(5), '0, 1'b0);
    add_insert({KEY_BITS{1'b1}}, {SCORE_BITS{1'b1}}, 1'b0);
    add_insert('0, SCORE_BITS'(10000), 1'b0);
    add_insert(KEY_BITS'(5), SCORE_BITS'(1), 1'b0);
    add_insert(KEY_BITS'(40'h55_5555_5555), SCORE_BITS'(14'h2AAA), 1'b0);
    add_insert(KEY_BITS'(40'hAA_AAAA_AAAA), SCORE_BITS'(14'h1555), 1'b0);
    add_delete(KEY_BITS'(6), 1'b0);
    add_delete(KEY_BITS'(5), 1'b0);
    add_delete({KEY_BITS{1'b1}}, 1'b0);
    add_delete('0, 1'b0);
    add_delete(KEY_BITS'(40'hAA_AAAA_AAAA), 1'b0);
    add_delete(KEY_BITS'(5), 1'b0);
    add_delete(KEY_BITS'(40'h55_5555_5555), 1'b0);
    add_delete(KEY_BITS'(40'hAA_AAAA_AAAA), 1'b0);

    // random phases; the first fills past full, the second is mostly deletes to drain it
    phase = 0;
    while (pending_requests.size() < ITEM_TARGET) begin
      if (phase == 0) begin
        ins_pct = 100;
        len     = TABLE_DEPTH + 8;
      end else if (phase == 1) begin
        ins_pct = 10;
        len     = 110;
      end else begin
        len = $urandom_range(30, 120);
        case ($urandom_range(0, 4))
          0:       ins_pct = 90;
          1:       ins_pct = 70;
          2:       ins_pct = 50;
          3:       ins_pct = 30;
          default: ins_pct = 10;
        endcase
      end
      for (int j = 0; j < len; j++) begin
        first = (j == 0) && (phase == 0 || $urandom_range(0, 3) == 0);
        if ($urandom_range(1, 100) <= ins_pct) begin
          add_insert(pick_key(), pick_score(), first);
        end else if (live_keys.size() != 0 && $urandom_range(0, 3) != 0) begin
          add_delete(live_keys[$urandom_range(0, live_keys.size() - 1)], first);
        end else begin
          add_delete(pick_key(), first);
        end
      end
      phase++;
    end

    while (pending_requests.size() != 0 || awaited_responses.size() != 0 || req_if.valid)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (awaited_responses.size() != 0) begin
      $error("%0d responses never arrived", awaited_responses.size());
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("sorted_key_table_insert_delete regression: pass");
    end else begin
      $display("sorted_key_table_insert_delete regression: fail");
    end
    $finish;
  end

  initial begin
    repeat (LIMIT_CYCLES) @(posedge clk);
    $display("sorted_key_table_insert_delete regression: fail");
    $finish;
  end

endmodule
